/* hdl/mptg_pkg.sv */
// Shared types and constants for the multichannel pulse train generator.
// No dependencies; imported by the top level.
package mptg_pkg;

  localparam int unsigned CHANNELS_DEF = 16;

  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned CHAN_W  = 4;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned AMP_W   = 8;
  localparam int unsigned TIME_W  = 16;
  localparam int unsigned MASK_W  = 16;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_START = 2'd1,
    FUNC_DRIVE = 2'd2,
    FUNC_STOP  = 2'd3
  } func_e;

  typedef enum logic [6:0] {
    ST_IDLE      = 7'b0000001,
    ST_SCAN      = 7'b0000010,
    ST_SCAN_LAST = 7'b0000100,
    ST_EMIT_RD   = 7'b0001000,
    ST_EMIT_WAIT = 7'b0010000,
    ST_DRIVE     = 7'b0100000,
    ST_START_OUT = 7'b1000000
  } state_e;

  // One channel's entry in the state memory.
  typedef struct packed {
    logic [AMP_W-1:0]   amp;
    logic [COUNT_W-1:0] pulses;
    logic [TIME_W-1:0]  on_dur;
    logic [TIME_W-1:0]  off_dur;
    logic [TIME_W-1:0]  cdown;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

/* hdl/multichannel_pulse_train_generator.sv */
// Multichannel pulse train generator: per-channel timing state in one RAM.
// Depends on mptg_pkg and mptg_ram.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+----------------------------------
//   in      | input     | in_valid_i / in_stall_o | func, channel, pulse_count, ...
//   out     | output    | out_valid_o / out_stall_i | out_channel, out_level, busy_mask, last
//
// A tick reads every channel once through the RAM's single read port and flushes
// the last one through the data stage. The result walk then reads and emits each
// switching channel in turn and steps past quiet channels below the last
// switching one; it ends at once when nothing switched. A start writes its
// entry and emits one result; immediate drive and stop-all emit one result per
// channel. Input stalls until a command's walk ends; an output stall holds the
// walk. Reset clears the task and phase flags; RAM entries are written before use.
module multichannel_pulse_train_generator #(
  parameter int unsigned CHANNELS = mptg_pkg::CHANNELS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [mptg_pkg::FUNC_W-1:0]   func_i,
  input  logic [mptg_pkg::CHAN_W-1:0]   channel_i,
  input  logic [mptg_pkg::COUNT_W-1:0]  pulse_count_i,
  input  logic [mptg_pkg::AMP_W-1:0]    amplitude_i,
  input  logic [mptg_pkg::TIME_W-1:0]   on_time_i,
  input  logic [mptg_pkg::TIME_W-1:0]   off_time_i,
  input  logic [mptg_pkg::MASK_W-1:0]   channel_mask_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [mptg_pkg::CHAN_W-1:0]   out_channel_o,
  output logic [mptg_pkg::AMP_W-1:0]    out_level_o,
  output logic [mptg_pkg::MASK_W-1:0]   busy_mask_o,
  output logic                          last_o
);
  import mptg_pkg::*;

  localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);

  state_e state_q, state_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic                p_valid_q, p_valid_d;
  logic [IDX_W-1:0]    p_idx_q, p_idx_d;
  logic [CHANNELS-1:0] active_q, active_d;
  logic [CHANNELS-1:0] phase_q, phase_d;
  logic [CHANNELS-1:0] emit_q, emit_d;
  logic [CHANNELS-1:0] emit_rest;

  // Command payload held while a command's results are emitted.
  logic [IDX_W-1:0]    cmd_ch_q, cmd_ch_d;
  logic [AMP_W-1:0]    cmd_amp_q, cmd_amp_d;
  logic [CHANNELS-1:0] cmd_mask_q, cmd_mask_d;

  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  entry_t           ram_wdata, ram_rdata, ent;
  logic [TIME_W-1:0]  cd_dec;
  logic [COUNT_W-1:0] pl_dec;

  logic             out_valid_q, out_valid_d;
  logic [IDX_W-1:0] out_ch_q, out_ch_d;
  logic [AMP_W-1:0] out_level_q, out_level_d;
  logic [MASK_W-1:0] busy_q, busy_d;
  logic             last_q, last_d;
  logic             out_free, ld;

  logic             start_ok;

  mptg_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CHANNELS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign start_ok   = (pulse_count_i != '0) &&
                      ({1'b0, channel_i} < (CHAN_W + 1)'(CHANNELS));

  assign ent    = ram_rdata;
  assign cd_dec = (ent.cdown != '0) ? ent.cdown - 1'b1 : '0;
  assign pl_dec = ent.pulses - 1'b1;
  assign emit_rest = emit_q & ~(CHANNELS'(1) << idx_q);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    p_valid_d   = 1'b0;
    p_idx_d     = p_idx_q;
    active_d    = active_q;
    phase_d     = phase_q;
    emit_d      = emit_q;
    cmd_ch_d    = cmd_ch_q;
    cmd_amp_d   = cmd_amp_q;
    cmd_mask_d  = cmd_mask_q;
    ram_we      = 1'b0;
    ram_waddr   = p_idx_q;
    ram_wdata   = ent;
    ram_re      = 1'b0;
    ram_raddr   = idx_q;
    ld          = 1'b0;
    out_ch_d    = idx_q;
    out_level_d = '0;
    last_d      = 1'b0;

    // Tick data stage: one channel per cycle, in the cycle after that channel's read.
    if (p_valid_q && active_q[p_idx_q]) begin
      ram_we    = 1'b1;
      ram_waddr = p_idx_q;
      if (cd_dec != '0) begin
        ram_wdata.cdown = cd_dec;
      end else if (phase_q[p_idx_q]) begin
        phase_d[p_idx_q]  = 1'b0;
        ram_wdata.cdown   = ent.off_dur;
        ram_wdata.pulses  = pl_dec;
        if (pl_dec == '0) begin
          active_d[p_idx_q] = 1'b0;
        end
        emit_d[p_idx_q] = 1'b1;
      end else begin
        phase_d[p_idx_q] = 1'b1;
        ram_wdata.cdown  = ent.on_dur;
        emit_d[p_idx_q]  = 1'b1;
      end
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (func_e'(func_i))
            FUNC_TICK: begin
              emit_d  = '0;
              idx_d   = '0;
              state_d = ST_SCAN;
            end
            FUNC_START: begin
              if (start_ok) begin
                ram_we            = 1'b1;
                ram_waddr         = channel_i[IDX_W-1:0];
                ram_wdata.amp     = amplitude_i;
                ram_wdata.pulses  = pulse_count_i;
                ram_wdata.on_dur  = on_time_i;
                ram_wdata.off_dur = off_time_i;
                ram_wdata.cdown   = on_time_i;
                active_d[channel_i[IDX_W-1:0]] = 1'b1;
                phase_d[channel_i[IDX_W-1:0]]  = 1'b1;
                cmd_ch_d  = channel_i[IDX_W-1:0];
                cmd_amp_d = amplitude_i;
                state_d   = ST_START_OUT;
              end
            end
            FUNC_DRIVE: begin
              active_d   = '0;
              cmd_amp_d  = amplitude_i;
              cmd_mask_d = channel_mask_i[CHANNELS-1:0];
              idx_d      = '0;
              state_d    = ST_DRIVE;
            end
            FUNC_STOP: begin
              active_d   = '0;
              cmd_amp_d  = '0;
              cmd_mask_d = '0;
              idx_d      = '0;
              state_d    = ST_DRIVE;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_SCAN: begin
        ram_re    = 1'b1;
        ram_raddr = idx_q;
        p_valid_d = 1'b1;
        p_idx_d   = idx_q;
        if (idx_q == LAST_IDX) begin
          idx_d   = '0;
          state_d = ST_SCAN_LAST;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_SCAN_LAST: begin
        // last channel is in the data stage this cycle
        idx_d   = '0;
        state_d = ST_EMIT_RD;
      end
      ST_EMIT_RD: begin
        if (emit_q == '0) begin
          state_d = ST_IDLE;
        end else if (emit_q[idx_q]) begin
          ram_re    = 1'b1;
          ram_raddr = idx_q;
          state_d   = ST_EMIT_WAIT;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_EMIT_WAIT: begin
        if (out_free) begin
          ld          = 1'b1;
          out_ch_d    = idx_q;
          out_level_d = phase_q[idx_q] ? ent.amp : '0;
          last_d      = (emit_rest == '0);
          emit_d      = emit_rest;
          if (emit_rest == '0) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_EMIT_RD;
          end
        end
      end
      ST_DRIVE: begin
        if (out_free) begin
          ld          = 1'b1;
          out_ch_d    = idx_q;
          out_level_d = cmd_mask_q[idx_q] ? cmd_amp_q : '0;
          last_d      = (idx_q == LAST_IDX);
          if (idx_q == LAST_IDX) begin
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      ST_START_OUT: begin
        if (out_free) begin
          ld          = 1'b1;
          out_ch_d    = cmd_ch_q;
          out_level_d = cmd_amp_q;
          last_d      = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Busy flags are final by the time any result of a command is loaded.
  assign busy_d = MASK_W'(active_q);

  always_comb begin
    out_valid_d = out_valid_q;
    if (ld) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      p_valid_q   <= 1'b0;
      active_q    <= '0;
      phase_q     <= '0;
      emit_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      p_valid_q   <= p_valid_d;
      active_q    <= active_d;
      phase_q     <= phase_d;
      emit_q      <= emit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_idx_q    <= p_idx_d;
    cmd_ch_q   <= cmd_ch_d;
    cmd_amp_q  <= cmd_amp_d;
    cmd_mask_q <= cmd_mask_d;
    if (ld) begin
      out_ch_q    <= out_ch_d;
      out_level_q <= out_level_d;
      busy_q      <= busy_d;
      last_q      <= last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_channel_o = CHAN_W'(out_ch_q);
  assign out_level_o   = out_level_q;
  assign busy_mask_o   = busy_q;
  assign last_o        = last_q;

endmodule

/* hdl/mptg_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module mptg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
